FILE: hdl/gyro_quaternion_integrator_macros.svh
// Assertion macros for the gyro quaternion integrator checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef GYRO_QUATERNION_INTEGRATOR_MACROS_SVH
`define GYRO_QUATERNION_INTEGRATOR_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define GQI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion, checked in every cycle
`define GQI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/gqi_pkg.sv
// Shared types and constants for the gyro quaternion integrator.
// No dependencies; used by the top level, the multiplier and the checker.
package gqi_pkg;

    localparam int QDIM      = 4;
    localparam int IN_W      = 104;
    localparam int OUT_W     = 128;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 64;

    localparam logic [31:0] SCALE_RESET    = 32'd37480;
    localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
    localparam logic [29:0] HALF_ANGLE_MAX = 30'h3FFF_FFFF;

    // Subtract flags of the derivative terms, bit {component, term}
    localparam logic [15:0] NEG_MASK = 16'h284E;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HMUL,
        ST_ANG,
        ST_VEC,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } gqi_state_t;

    // Operand pair for the shared multiplier
    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } gqi_mul_req_t;

endpackage

FILE: hdl/gqi_mul.sv
// Shared signed 33x33 multiplier with a registered product.
// Depends on gqi_pkg for operand and product widths.
module gqi_mul (
    input  logic                          clk,
    input  gqi_pkg::gqi_mul_req_t         req,
    output logic signed [gqi_pkg::PROD_W-1:0] prod
);
    import gqi_pkg::*;

    logic signed [2*MUL_W-1:0] full;
    logic signed [PROD_W-1:0]  prod_reg;

    // Full product; only the low 64 bits are ever significant
    assign full = req.a * req.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/gyro_quaternion_integrator.sv
// Gyro quaternion integrator top level: sequencer, datapath registers, ports.
// Depends on gqi_pkg and gqi_mul.
//
// Integrates three-axis gyro rates (Q16.8 deg/s) into a unit attitude
// quaternion (Q2.30, w x y z from the low bits of m_axis_tdata). The first
// sample after reset only records its tick and produces no result; every
// later sample produces one quaternion. Once a sample is accepted, ready
// stays low (shorter when the vector collapses to zero) while the
// sequencer runs the tick product, the half angles and the derivative
// sums on the shared multiplier, the range shift, the sum of squares,
// the bit-serial square root and four 31-step divisions. A finished
// result waits in an output register while the next sample is accepted.
// The scale register is written through cfg_valid/cfg_data and always
// ready.
module gyro_quaternion_integrator (
    input  logic                       clk,
    input  logic                       rst_n,
    // s_axis_tdata: rate_x[23:0], rate_y[47:24], rate_z[71:48], sample_tick[103:72]
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [gqi_pkg::IN_W-1:0]   s_axis_tdata,
    // m_axis_tdata: quat_w[31:0], quat_x[63:32], quat_y[95:64], quat_z[127:96]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [gqi_pkg::OUT_W-1:0]  m_axis_tdata,
    // half_period_scale write request
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [31:0]                cfg_data
);
    import gqi_pkg::*;

    // Control state
    gqi_state_t         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               ph_reg, ph_next;
    logic [1:0]         comp_reg, comp_next;
    logic [31:0]        scale_reg, scale_next;
    logic [31:0]        prev_tick_reg, prev_tick_next;
    logic               have_prev_reg, have_prev_next;
    logic signed [31:0] q_reg [QDIM];
    logic signed [31:0] q_next [QDIM];
    logic               out_valid_reg, out_valid_next;

    // Datapath payload
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic [31:0]        dt_reg, dt_next;
    logic signed [23:0] rate_reg [3];
    logic signed [23:0] rate_next [3];
    logic [63:0]        h_reg, h_next;
    logic [55:0]        plo_reg, plo_next;
    logic signed [30:0] a_reg [3];
    logic signed [30:0] a_next [3];
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0]        mg_reg [QDIM];
    logic [63:0]        mg_next [QDIM];
    logic               sign_reg [QDIM];
    logic               sign_next [QDIM];
    logic [63:0]        sum_reg, sum_next;
    logic [63:0]        rad_reg, rad_next;
    logic [35:0]        rem_reg, rem_next;
    logic [31:0]        root_reg, root_next;
    logic [31:0]        drem_reg, drem_next;
    logic [30:0]        dnum_reg, dnum_next;
    logic [30:0]        quo_reg, quo_next;

    gqi_mul_req_t       mul_req;
    logic signed [PROD_W-1:0] prod;

    gqi_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // Magnitude of a Q16.8 rate
    function automatic logic [23:0] rate_mag(input logic signed [23:0] r);
        rate_mag = r[23] ? (~r + 24'd1) : r;
    endfunction

    // Operand selection for the shared multiplier
    always_comb
    begin
        logic [1:0] axis;
        logic [1:0] term;
        logic [1:0] qsel;
        axis    = cnt_reg[2:1];
        term    = cnt_reg[1:0];
        qsel    = cnt_reg[3:2] ^ cnt_reg[1:0];
        mul_req = '0;
        case (state_reg)
            ST_HMUL:
            begin
                mul_req.a = {1'b0, dt_reg};
                mul_req.b = {1'b0, scale_reg};
            end
            ST_ANG:
            begin
                mul_req.a = {9'b0, rate_mag(rate_reg[axis])};
                mul_req.b = cnt_reg[0] ? {1'b0, h_reg[63:32]} : {1'b0, h_reg[31:0]};
            end
            ST_VEC:
            begin
                mul_req.a = {q_reg[qsel][31], q_reg[qsel]};
                case (term)
                    2'd1:    mul_req.b = {{2{a_reg[0][30]}}, a_reg[0]};
                    2'd2:    mul_req.b = {{2{a_reg[1][30]}}, a_reg[1]};
                    2'd3:    mul_req.b = {{2{a_reg[2][30]}}, a_reg[2]};
                    default: mul_req.b = {1'b0, ONE_Q30};
                endcase
            end
            ST_SQ:
            begin
                mul_req.a = {2'b0, mg_reg[cnt_reg[1:0]][30:0]};
                mul_req.b = {2'b0, mg_reg[cnt_reg[1:0]][30:0]};
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        logic [1:0]         axis;
        logic [55:0]        phi;
        logic [46:0]        mt;
        logic               sat;
        logic [29:0]        m30;
        logic signed [30:0] amag;
        logic signed [63:0] term_v;
        logic signed [63:0] accn;
        logic               big;
        logic [63:0]        sumn;
        logic [35:0]        rs;
        logic [35:0]        trial;
        logic [61:0]        num;
        logic [32:0]        r2;
        logic               ge;
        logic [30:0]        qf;
        logic signed [31:0] qmag;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ph_next        = ph_reg;
        comp_next      = comp_reg;
        scale_next     = scale_reg;
        prev_tick_next = prev_tick_reg;
        have_prev_next = have_prev_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        dt_next        = dt_reg;
        rate_next      = rate_reg;
        h_next         = h_reg;
        plo_next       = plo_reg;
        a_next         = a_reg;
        acc_next       = acc_reg;
        mg_next        = mg_reg;
        sign_next      = sign_reg;
        sum_next       = sum_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        dnum_next      = dnum_reg;
        quo_next       = quo_reg;

        axis   = cnt_reg[2:1];
        phi    = prod[55:0];
        mt     = {17'b0, phi[7:0], 22'b0} + {1'b0, plo_reg[55:10]};
        sat    = (|phi[55:8]) || (mt > {17'b0, HALF_ANGLE_MAX});
        m30    = sat ? HALF_ANGLE_MAX : mt[29:0];
        amag   = {1'b0, m30};
        term_v = NEG_MASK[cnt_reg[3:0]] ? -prod : prod;
        accn   = ((cnt_reg[1:0] == 2'd0) ? 64'sd0 : acc_reg) + term_v;
        big    = (|mg_reg[0][63:31]) || (|mg_reg[1][63:31])
              || (|mg_reg[2][63:31]) || (|mg_reg[3][63:31]);
        sumn   = ((cnt_reg[1:0] == 2'd0) ? 64'd0 : sum_reg) + prod;
        rs     = {rem_reg[33:0], rad_reg[63:62]};
        trial  = {2'b0, root_reg, 2'b01};
        num    = {1'b0, mg_reg[comp_reg][30:0], 30'b0} + {31'b0, root_reg[31:1]};
        r2     = {drem_reg, dnum_reg[30]};
        ge     = r2 >= {1'b0, root_reg};
        qf     = {quo_reg[29:0], ge};
        qmag   = {1'b0, qf};

        // Scale register write, always accepted
        if (cfg_valid)
        begin
            scale_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    prev_tick_next = s_axis_tdata[103:72];
                    if (!have_prev_reg)
                    begin
                        have_prev_next = 1'b1;
                    end
                    else
                    begin
                        dt_next      = s_axis_tdata[103:72] - prev_tick_reg;
                        rate_next[0] = s_axis_tdata[23:0];
                        rate_next[1] = s_axis_tdata[47:24];
                        rate_next[2] = s_axis_tdata[71:48];
                        ph_next      = 1'b0;
                        state_next   = ST_HMUL;
                    end
                end
            end
            // h = dt * scale
            ST_HMUL:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    h_next     = prod;
                    cnt_next   = '0;
                    state_next = ST_ANG;
                end
            end
            // Half angles: low then high partial product per axis
            ST_ANG:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    if (!cnt_reg[0])
                    begin
                        plo_next = phi;
                    end
                    else
                    begin
                        a_next[axis] = rate_reg[axis][23] ? -amag : amag;
                    end
                    if (cnt_reg == 5'd5)
                    begin
                        cnt_next   = '0;
                        state_next = ST_VEC;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            // Quaternion plus derivative, four terms per component
            ST_VEC:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    acc_next = accn;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        mg_next[cnt_reg[3:2]]   = accn[63] ? -accn : accn;
                        sign_next[cnt_reg[3:2]] = accn[63];
                    end
                    if (cnt_reg == 5'd15)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            // Bring every magnitude below 2^31
            ST_SHIFT:
            begin
                if (big)
                begin
                    for (int i = 0; i < QDIM; i++)
                    begin
                        mg_next[i] = mg_reg[i] >> 1;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    ph_next    = 1'b0;
                    state_next = ST_SQ;
                end
            end
            // Sum of squares
            ST_SQ:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    sum_next = sumn;
                    if (cnt_reg == 5'd3)
                    begin
                        cnt_next = '0;
                        if (sumn == 64'd0)
                        begin
                            // zero vector collapses to identity
                            q_next[0]  = ONE_Q30;
                            q_next[1]  = '0;
                            q_next[2]  = '0;
                            q_next[3]  = '0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            rad_next   = sumn;
                            rem_next   = '0;
                            root_next  = '0;
                            state_next = ST_SQRT;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 5'd1;
                    end
                end
            end
            // Restoring square root, one result bit per cycle
            ST_SQRT:
            begin
                rad_next = {rad_reg[61:0], 2'b00};
                if (rs >= trial)
                begin
                    rem_next  = rs - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rs;
                    root_next = {root_reg[30:0], 1'b0};
                end
                if (cnt_reg == 5'd31)
                begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            // Rounded numerator; its top half is already below the root
            ST_DIV_INIT:
            begin
                drem_next  = {1'b0, num[61:31]};
                dnum_next  = num[30:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            // Restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                drem_next = ge ? 32'(r2 - {1'b0, root_reg}) : r2[31:0];
                dnum_next = {dnum_reg[29:0], 1'b0};
                quo_next  = qf;
                if (cnt_reg == 5'd30)
                begin
                    q_next[comp_reg] = sign_reg[comp_reg] ? -qmag : qmag;
                    cnt_next         = '0;
                    if (comp_reg == 2'd3)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DIV_INIT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            // Hand the new attitude to the output register
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ph_reg        <= 1'b0;
            comp_reg      <= '0;
            scale_reg     <= SCALE_RESET;
            prev_tick_reg <= '0;
            have_prev_reg <= 1'b0;
            q_reg[0]      <= ONE_Q30;
            q_reg[1]      <= '0;
            q_reg[2]      <= '0;
            q_reg[3]      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ph_reg        <= ph_next;
            comp_reg      <= comp_next;
            scale_reg     <= scale_next;
            prev_tick_reg <= prev_tick_next;
            have_prev_reg <= have_prev_next;
            q_reg         <= q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        dt_reg       <= dt_next;
        rate_reg     <= rate_next;
        h_reg        <= h_next;
        plo_reg      <= plo_next;
        a_reg        <= a_next;
        acc_reg      <= acc_next;
        mg_reg       <= mg_next;
        sign_reg     <= sign_next;
        sum_reg      <= sum_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        drem_reg     <= drem_next;
        dnum_reg     <= dnum_next;
        quo_reg      <= quo_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

endmodule

FILE: hdl/gqi_checker.sv
// Port-level checker for the gyro quaternion integrator, bound to the top.
// Depends on gqi_pkg and gyro_quaternion_integrator_macros.svh.
`include "gyro_quaternion_integrator_macros.svh"

module gqi_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [gqi_pkg::OUT_W-1:0] m_axis_tdata
);
    import gqi_pkg::*;

    // A stalled result request stays up
    `GQI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its data
    `GQI_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result data changed while stalled")

    // A new result appears as the sequencer returns to ready
    `GQI_ASSERT(a_out_on_finish, $rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready), "result appeared outside sequence end")

    // Ready only returns with a result waiting or taken
    `GQI_ASSERT(a_ready_with_result, $rose(s_axis_tready) |-> m_axis_tvalid, "sequence ended without a result")

endmodule

bind gyro_quaternion_integrator gqi_checker u_gqi_checker (.*);
